>>> hw/rtl/lmf_pkg.sv
// Package: pixel types, frame limits and luma weights of the median filter.
`timescale 1ns / 1ps
`default_nettype none
package lmf_pkg;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int CHAN_W       = 16;
    localparam int CFG_W        = 11;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int CNT_W        = 11;
    localparam int LUMA_W       = 32;

    localparam logic [15:0] WEIGHT_R = 16'd19595;
    localparam logic [15:0] WEIGHT_G = 16'd38470;
    localparam logic [15:0] WEIGHT_B = 16'd7471;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic left_out;
        logic right_out;
        logic top_out;
        logic bottom_out;
        logic eof;
        logic use_old;
    } t_pos;

    function automatic logic [LUMA_W-1:0] luma(input t_pix p);
        logic [LUMA_W-1:0] yr;
        logic [LUMA_W-1:0] yg;
        logic [LUMA_W-1:0] yb;
        yr = {16'd0, p.red}   * {16'd0, WEIGHT_R};
        yg = {16'd0, p.green} * {16'd0, WEIGHT_G};
        yb = {16'd0, p.blue}  * {16'd0, WEIGHT_B};
        return yr + yg + yb;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/lmf_in_if.sv
// Interface: input word channel (opcode and RGB pixel).
`timescale 1ns / 1ps
`default_nettype none
interface lmf_in_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [lmf_pkg::CHAN_W-1:0] in_red;
    logic [lmf_pkg::CHAN_W-1:0] in_green;
    logic [lmf_pkg::CHAN_W-1:0] in_blue;
    modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lmf_out_if.sv
// Interface: output word channel (median RGB pixel and end of frame).
`timescale 1ns / 1ps
`default_nettype none
interface lmf_out_if;
    logic                      valid;
    logic                      ready;
    logic [lmf_pkg::CHAN_W-1:0] out_red;
    logic [lmf_pkg::CHAN_W-1:0] out_green;
    logic [lmf_pkg::CHAN_W-1:0] out_blue;
    logic                      end_of_frame;
    modport source (output valid, out_red, out_green, out_blue, end_of_frame, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, end_of_frame, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/luminance_median_filter_3x3.sv
// Top level: 3x3 luma-ranked median filter over a raster RGB stream.
//
// Input channel i_in carries one word per pixel (opcode pixel) or a flush
// tick (opcode flush). Output channel o_out carries the RGB of the window
// pixel whose luma ranks fifth, with end_of_frame on the bottom-right pixel.
// Frame size comes from the write port (index 0 width, 1 height); a write
// restarts the frame position.
// Throughput: one word per cycle while the receiver takes results. The line stores
// are two synchronous RAMs read when a word is taken and written back when that
// word leaves stage 1; a same-column write and read in the same cycle is forwarded.
// The result for a pixel comes with the word one row and one pixel later, then
// passes the RAM read, window, luma and rank registers on its way to o_out.
// After the last pixel, width + 1 flush words drain the last row.
// Reset clears the frame position and the pipeline valids; the RAMs need no
// clearing. When the receiver stalls, the result holds in the output
// register and the stages behind it keep filling until all are occupied.
`timescale 1ns / 1ps
`default_nettype none
module luminance_median_filter_3x3 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    lmf_in_if.sink                         i_in,
    lmf_out_if.source                      o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [lmf_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int CW = lmf_pkg::COL_W;
    localparam int NW = lmf_pkg::CNT_W;

    logic [lmf_pkg::CFG_W-1:0] r_fw, r_fh;
    logic [CW-1:0] r_col;
    logic [NW-1:0] r_row, r_flush;

    lmf_pkg::t_pix mem_up  [lmf_pkg::MAX_WIDTH];
    lmf_pkg::t_pix mem_mid [lmf_pkg::MAX_WIDTH];
    lmf_pkg::t_pix r_rd_up, r_rd_mid, r_fwd_up, r_fwd_mid;
    logic r_fwd;

    logic          r_v1, r_v2, r_v3, r_vo;
    logic [CW-1:0] r_s1_c;
    lmf_pkg::t_pix r_s1_cur;
    logic          r_s1_emit;
    lmf_pkg::t_pos r_s1_pos;
    lmf_pkg::t_pix r_win [9];
    lmf_pkg::t_pix r_s2_nb [9];
    logic          r_s2_eof;
    lmf_pkg::t_pix r_s3_nb [9];
    logic [lmf_pkg::LUMA_W-1:0] r_s3_lu [9];
    logic          r_s3_eof;
    lmf_pkg::t_pix r_o_pix;
    logic          r_o_eof;

    logic [NW-1:0] w, h, wm1;
    logic flush, drop, restart, acc, take;
    logic [CW-1:0] c0, n_col, x;
    logic [NW-1:0] r0, f0, n_row, n_flush, col_inc, y;
    logic emit;
    lmf_pkg::t_pos pos;
    logic adv1, adv2, adv3, adv_o;
    lmf_pkg::t_pix cur, eff_up, eff_mid, centre;
    lmf_pkg::t_pix n_win [9];
    lmf_pkg::t_pix src [9];
    lmf_pkg::t_pix nb [9];
    lmf_pkg::t_pix sel;
    logic [1:0] cc;

    // frame geometry
    always_comb begin
        if (r_fw == '0) begin
            w = NW'(1);
        end else if (r_fw > lmf_pkg::CFG_W'(lmf_pkg::MAX_WIDTH)) begin
            w = NW'(lmf_pkg::MAX_WIDTH);
        end else begin
            w = NW'(r_fw);
        end
        if (r_fh == '0) begin
            h = NW'(1);
        end else if (r_fh > lmf_pkg::CFG_W'(lmf_pkg::HEIGHT_LIMIT)) begin
            h = NW'(lmf_pkg::HEIGHT_LIMIT);
        end else begin
            h = NW'(r_fh);
        end
        wm1 = w - NW'(1);
    end

    assign adv_o = !r_vo || o_out.ready;
    assign adv3  = !r_v3 || adv_o;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign i_in.ready = adv1;
    assign acc   = i_in.valid && adv1;

    assign flush   = (i_in.opcode == lmf_pkg::OP_FLUSH);
    assign drop    = flush && (r_row < h);
    assign restart = !flush && (r_row >= h);
    assign take    = acc && !drop;

    always_comb begin
        c0 = restart ? '0 : r_col;
        r0 = restart ? '0 : r_row;
        f0 = restart ? '0 : r_flush;
        cur.red   = flush ? '0 : i_in.in_red;
        cur.green = flush ? '0 : i_in.in_green;
        cur.blue  = flush ? '0 : i_in.in_blue;
        if (c0 == '0) begin
            emit = (r0 >= NW'(2));
            x    = wm1[CW-1:0];
            y    = r0 - NW'(2);
        end else begin
            emit = (r0 >= NW'(1));
            x    = c0 - CW'(1);
            y    = r0 - NW'(1);
        end
        pos.use_old    = (c0 == '0);
        pos.left_out   = (x == '0);
        pos.right_out  = (c0 == '0) || (NW'(x) == wm1);
        pos.top_out    = (y == '0);
        pos.bottom_out = (y == h - NW'(1));
        pos.eof        = (NW'(x) == wm1) && (y == h - NW'(1));
        n_flush = f0 + NW'(flush);
        col_inc = NW'(c0) + NW'(1);
        if (col_inc >= w) begin
            n_col = '0;
            n_row = r0 + NW'(1);
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = r0;
        end
        if (flush && (n_flush >= w + NW'(1))) begin
            n_col   = '0;
            n_row   = '0;
            n_flush = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= lmf_pkg::CFG_W'(640);
            r_fh    <= lmf_pkg::CFG_W'(480);
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == lmf_pkg::CFG_WIDTH) begin
                r_fw <= i_cfg_data;
            end else begin
                r_fh <= i_cfg_data;
            end
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else if (take) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

    // line store RAMs
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_up  <= mem_up[c0];
            r_rd_mid <= mem_mid[c0];
        end
        if (r_v1 && adv2) begin
            mem_up[r_s1_c]  <= eff_mid;
            mem_mid[r_s1_c] <= r_s1_cur;
        end
    end

    assign eff_up  = r_fwd ? r_fwd_up  : r_rd_up;
    assign eff_mid = r_fwd ? r_fwd_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
        end else if (adv1) begin
            r_v1  <= take;
            r_fwd <= r_v1 && (r_s1_c == c0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_c    <= c0;
            r_s1_cur  <= cur;
            r_s1_emit <= emit;
            r_s1_pos  <= pos;
            r_fwd_up  <= eff_mid;
            r_fwd_mid <= r_s1_cur;
        end
    end

    // window build and edge replacement
    always_comb begin
        int dr, dc, col;
        logic out_n;
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]   = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = eff_up;
        n_win[5] = eff_mid;
        n_win[8] = r_s1_cur;
        for (int k = 0; k < 9; k++) begin
            src[k] = r_s1_pos.use_old ? r_win[k] : n_win[k];
        end
        cc     = r_s1_pos.use_old ? 2'd2 : 2'd1;
        centre = src[3 + int'(cc)];
        for (int k = 0; k < 9; k++) begin
            dr    = k / 3;
            dc    = k % 3;
            col   = int'(cc) + dc - 1;
            out_n = (dr == 0 && r_s1_pos.top_out) || (dr == 2 && r_s1_pos.bottom_out)
                 || (dc == 0 && r_s1_pos.left_out) || (dc == 2 && r_s1_pos.right_out)
                 || col < 0 || col > 2;
            nb[k] = out_n ? centre : src[dr*3 + ((col < 0 || col > 2) ? 0 : col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1 && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && adv2) begin
            r_win    <= n_win;
            r_s2_nb  <= nb;
            r_s2_eof <= r_s1_pos.eof;
        end
    end

    // luma
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && adv3) begin
            r_s3_nb  <= r_s2_nb;
            r_s3_eof <= r_s2_eof;
            for (int k = 0; k < 9; k++) begin
                r_s3_lu[k] <= lmf_pkg::luma(r_s2_nb[k]);
            end
        end
    end

    // rank select
    always_comb begin
        logic [3:0] rank;
        sel = r_s3_nb[4];
        for (int i = 8; i >= 0; i--) begin
            rank = '0;
            for (int j = 0; j < 9; j++) begin
                if (r_s3_lu[j] < r_s3_lu[i] || (r_s3_lu[j] == r_s3_lu[i] && j < i)) begin
                    rank = rank + 4'd1;
                end
            end
            if (rank == 4'd4) begin
                sel = r_s3_nb[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv_o) begin
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && adv_o) begin
            r_o_pix <= sel;
            r_o_eof <= r_s3_eof;
        end
    end

    assign o_out.valid        = r_vo;
    assign o_out.out_red      = r_o_pix.red;
    assign o_out.out_green    = r_o_pix.green;
    assign o_out.out_blue     = r_o_pix.blue;
    assign o_out.end_of_frame = r_o_eof;
endmodule
`default_nettype wire

>>> hw/rtl/lmf_checker.sv
// Checker: port-level properties of the median filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lmf_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [lmf_pkg::CHAN_W-1:0] i_out_red,
    input wire logic                      i_out_eof
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_red) && $stable(i_out_eof))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");
endmodule

bind luminance_median_filter_3x3 lmf_checker u_lmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_red   (o_out.out_red),
    .i_out_eof   (o_out.end_of_frame)
);
`default_nettype wire

>>> tb/tb_luminance_median_filter_3x3.sv
// Testbench: random and directed frames checked word by word against a built-in median predictor.
`timescale 1ns / 1ps
module tb_luminance_median_filter_3x3;

    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_WORDS = 350;

    typedef enum {K_WORD, K_CFG, K_PAUSE, K_HOLD, K_CALM} t_kind;

    typedef struct {
        t_kind                     kind;
        logic                      op;
        lmf_pkg::t_pix             px;
        logic                      idx;
        logic [lmf_pkg::CFG_W-1:0] data;
        bit                        flag;
    } t_token;

    typedef struct {
        lmf_pkg::t_pix px;
        logic          eof;
    } t_median;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_index = lmf_pkg::CFG_WIDTH;
    logic [lmf_pkg::CFG_W-1:0] cfg_data = '0;

    lmf_in_if  in_ch ();
    lmf_out_if out_ch ();

    luminance_median_filter_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    t_token  words[$];
    t_median median_q[$];

    lmf_pkg::t_pix upper_row[lmf_pkg::MAX_WIDTH];
    lmf_pkg::t_pix middle_row[lmf_pkg::MAX_WIDTH];
    lmf_pkg::t_pix window[9];
    int          col_cnt = 0;
    int          row_cnt = 0;
    int          flush_cnt = 0;
    int          width_reg = 640;
    int          height_reg = 480;

    bit          failed = 0;
    bit          calm = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          sink_hold = 0;
    int          quiet = 0;
    int          cycles = 0;
    int          pushed = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = lmf_pkg::OP_PIXEL;
        in_ch.in_red = '0;
        in_ch.in_green = '0;
        in_ch.in_blue = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 9; i++) window[i] = '0;
    end

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int n;
        n = $urandom_range(0, 99);
        if (calm) return 0;
        if (n < 60) return 0;
        if (n < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [33:0] luma_of(lmf_pkg::t_pix p);
        return 34'(p.red) * 34'd19595 + 34'(p.green) * 34'd38470 + 34'(p.blue) * 34'd7471;
    endfunction

    function automatic lmf_pkg::t_pix rank_fifth(lmf_pkg::t_pix w[9], int cc, bit lo, bit ro,
                                                 bit to, bit bo);
        lmf_pkg::t_pix nb[9];
        logic [33:0]   lu[9];
        lmf_pkg::t_pix centre;
        int            col, k, rank;
        bit            outside;
        centre = w[3 + cc];
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                col = cc + dc;
                k = (dr + 1) * 3 + (dc + 1);
                outside = (dr < 0 && to) || (dr > 0 && bo) || (dc < 0 && lo) ||
                          (dc > 0 && ro) || col < 0 || col > 2;
                nb[k] = outside ? centre : w[(dr + 1) * 3 + col];
                lu[k] = luma_of(nb[k]);
            end
        end
        for (int i = 0; i < 9; i++) begin
            rank = 0;
            for (int j = 0; j < 9; j++) begin
                if (lu[j] < lu[i] || (lu[j] == lu[i] && j < i)) rank++;
            end
            if (rank == 4) return nb[i];
        end
        return centre;
    endfunction

    function automatic void restart_position();
        col_cnt = 0;
        row_cnt = 0;
        flush_cnt = 0;
    endfunction

    function automatic void take_word(logic op, lmf_pkg::t_pix px);
        int            w, h, c, r, x, y;
        bit            emit;
        lmf_pkg::t_pix cur;
        lmf_pkg::t_pix sel;
        lmf_pkg::t_pix old[9];
        t_median       m;
        w = width_reg < 1 ? 1 :
            (width_reg > lmf_pkg::MAX_WIDTH ? lmf_pkg::MAX_WIDTH : width_reg);
        h = height_reg < 1 ? 1 :
            (height_reg > lmf_pkg::HEIGHT_LIMIT ? lmf_pkg::HEIGHT_LIMIT : height_reg);
        emit = 0;
        x = 0;
        y = 0;
        if (op == lmf_pkg::OP_FLUSH && row_cnt < h) return;
        if (op == lmf_pkg::OP_PIXEL && row_cnt >= h) restart_position();
        cur = (op == lmf_pkg::OP_FLUSH) ? lmf_pkg::t_pix'('0) : px;
        c = col_cnt;
        r = row_cnt;
        old = window;
        for (int k = 0; k < 3; k++) begin
            window[k * 3 + 0] = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2] = upper_row[c];
        window[5] = middle_row[c];
        window[8] = cur;
        upper_row[c] = middle_row[c];
        middle_row[c] = cur;
        if (c == 0) begin
            if (r >= 2 && r - 2 < h) begin
                x = w - 1;
                y = r - 2;
                sel = rank_fifth(old, 2, x == 0, 1'b1, y == 0, y == h - 1);
                emit = 1;
            end
        end else if (r >= 1 && r - 1 < h) begin
            x = c - 1;
            y = r - 1;
            sel = rank_fifth(window, 1, x == 0, x == w - 1, y == 0, y == h - 1);
            emit = 1;
        end
        if (emit) begin
            m.px = sel;
            m.eof = (x == w - 1 && y == h - 1);
            median_q.push_back(m);
        end
        if (op == lmf_pkg::OP_FLUSH) flush_cnt++;
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (op == lmf_pkg::OP_FLUSH && flush_cnt >= w + 1) restart_position();
    endfunction

    function automatic void push_tok(t_kind kind, logic op, lmf_pkg::t_pix px, logic idx,
                                     logic [lmf_pkg::CFG_W-1:0] data, bit flag);
        t_token t;
        t.kind = kind;
        t.op = op;
        t.px = px;
        t.idx = idx;
        t.data = data;
        t.flag = flag;
        words.push_back(t);
        if (kind == K_WORD) pushed++;
    endfunction

    function automatic void push_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        push_tok(K_WORD, lmf_pkg::OP_PIXEL, {r, g, b}, lmf_pkg::CFG_WIDTH, '0, 0);
    endfunction

    function automatic void push_flushes(int n);
        for (int i = 0; i < n; i++) begin
            push_tok(K_WORD, lmf_pkg::OP_FLUSH, lmf_pkg::t_pix'($urandom),
                     lmf_pkg::CFG_WIDTH, '0, 0);
        end
    endfunction

    function automatic void push_cfg(logic idx, int value);
        push_tok(K_CFG, lmf_pkg::OP_PIXEL, '0, idx, lmf_pkg::CFG_W'(value), 0);
    endfunction

    function automatic void push_ctrl(t_kind kind, bit flag);
        push_tok(kind, lmf_pkg::OP_PIXEL, '0, lmf_pkg::CFG_WIDTH, '0, flag);
    endfunction

    function automatic logic [15:0] pick_chan(int style);
        case (style)
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: return 16'($urandom_range(0, 3) * 21845);
            default: return 16'($urandom);
        endcase
    endfunction

    // frame of w x h pixels; noise inserts ignored flushes, drain may be cut short
    function automatic void push_frame(int w, int h, int style, bit noise, int drain);
        int g;
        for (int i = 0; i < w * h; i++) begin
            if (noise && $urandom_range(0, 9) == 0) push_flushes(1);
            if (style == 2) begin
                g = pick_chan(2);
                push_pixel(16'(g), 16'(g), 16'(g));
            end else begin
                push_pixel(pick_chan(style), pick_chan(style), pick_chan(style));
            end
        end
        push_flushes(drain);
    endfunction

    initial begin
        int w, h, n;
        push_cfg(lmf_pkg::CFG_WIDTH, 3);
        push_cfg(lmf_pkg::CFG_HEIGHT, 2);
        push_pixel(16'h0000, 16'h0000, 16'h0000);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_flushes(1);
        push_pixel(16'hFFFF, 16'h0000, 16'h0000);
        push_pixel(16'h0000, 16'hFFFF, 16'h0000);
        push_pixel(16'h0000, 16'h0000, 16'hFFFF);
        push_pixel(16'h0001, 16'h0001, 16'h0001);
        push_flushes(4);
        push_flushes(1);
        push_frame(3, 2, 2, 0, 2);
        push_frame(3, 2, 1, 0, 4);
        push_cfg(lmf_pkg::CFG_WIDTH, 0);
        push_cfg(lmf_pkg::CFG_HEIGHT, 0);
        push_frame(1, 1, 0, 0, 2);
        push_ctrl(K_PAUSE, 0);
        push_cfg(lmf_pkg::CFG_WIDTH, 2047);
        push_cfg(lmf_pkg::CFG_HEIGHT, 2);
        push_frame(5, 1, 0, 0, 0);
        push_cfg(lmf_pkg::CFG_WIDTH, 1);
        push_cfg(lmf_pkg::CFG_HEIGHT, 2047);
        push_frame(1, 3, 0, 0, 0);
        push_cfg(lmf_pkg::CFG_WIDTH, 8);
        push_cfg(lmf_pkg::CFG_HEIGHT, 6);
        push_ctrl(K_CALM, 1);
        push_ctrl(K_HOLD, 0);
        push_frame(8, 6, 0, 0, 9);
        push_ctrl(K_CALM, 0);
        n = pushed;
        while (pushed < n + RANDOM_WORDS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            if ($urandom_range(0, 7) == 0) push_ctrl(K_CALM, $urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) push_ctrl(K_PAUSE, 0);
            push_cfg(lmf_pkg::CFG_WIDTH, w);
            push_cfg(lmf_pkg::CFG_HEIGHT, h);
            case ($urandom_range(0, 9))
                0: push_frame(w, h, 0, 0, $urandom_range(0, w));
                1: push_frame(w, h, 2, 1, w + 1);
                2: push_frame(w, h, 1, 1, w + 1);
                default: push_frame(w, h, 0, $urandom_range(0, 3) == 0, w + 1);
            endcase
        end
        push_ctrl(K_CALM, 0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (words.size() != 0 || median_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (!failed && median_q.size() == 0) begin
            $display("luminance_median_filter_3x3: match");
        end else begin
            $display("luminance_median_filter_3x3: mismatch");
        end
        $finish;
    end

    // drive input words and register writes
    always @(negedge i_clk) begin
        t_token t;
        bit     v, we;
        v = 0;
        we = 0;
        if (i_rst_n) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (words.size() != 0) begin
                t = words[0];
                case (t.kind)
                    K_WORD: begin
                        v = 1;
                        in_ch.opcode <= t.op;
                        in_ch.in_red <= t.px.red;
                        in_ch.in_green <= t.px.green;
                        in_ch.in_blue <= t.px.blue;
                    end
                    K_CFG: begin
                        if (median_q.size() == 0 && quiet >= DRAIN_CYCLES) begin
                            we = 1;
                            cfg_index <= t.idx;
                            cfg_data <= t.data;
                            if (t.idx == lmf_pkg::CFG_WIDTH) width_reg = t.data;
                            else height_reg = t.data;
                            restart_position();
                            void'(words.pop_front());
                        end
                    end
                    K_PAUSE: begin
                        if (median_q.size() == 0 && quiet >= DRAIN_CYCLES) void'(words.pop_front());
                    end
                    K_HOLD: begin
                        sink_hold = HOLD_CYCLES;
                        void'(words.pop_front());
                    end
                    default: begin
                        calm = t.flag;
                        void'(words.pop_front());
                    end
                endcase
            end
        end
        in_ch.valid <= v;
        cfg_we <= we;
    end

    // drive output ready; hold off for a long stretch on request
    always @(negedge i_clk) begin
        bit rdy;
        rdy = 0;
        if (i_rst_n) begin
            if (sink_hold > 0) begin
                sink_hold--;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end else begin
                rdy = 1;
            end
        end
        out_ch.ready <= rdy;
    end

    // accept words into the predictor and check median words
    always @(posedge i_clk) begin
        t_median m;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("luminance_median_filter_3x3: mismatch");
            $finish;
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            take_word(in_ch.opcode, {in_ch.in_red, in_ch.in_green, in_ch.in_blue});
            void'(words.pop_front());
            src_gap = pick_gap();
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (median_q.size() == 0) begin
                $error("unexpected median word");
                failed = 1;
            end else begin
                m = median_q.pop_front();
                if (out_ch.out_red !== m.px.red) begin
                    $error("out_red expected %h actual %h", m.px.red, out_ch.out_red);
                    failed = 1;
                end
                if (out_ch.out_green !== m.px.green) begin
                    $error("out_green expected %h actual %h", m.px.green, out_ch.out_green);
                    failed = 1;
                end
                if (out_ch.out_blue !== m.px.blue) begin
                    $error("out_blue expected %h actual %h", m.px.blue, out_ch.out_blue);
                    failed = 1;
                end
                if (out_ch.end_of_frame !== m.eof) begin
                    $error("end_of_frame expected %b actual %b", m.eof, out_ch.end_of_frame);
                    failed = 1;
                end
            end
            sink_gap = pick_gap();
        end
        if (median_q.size() == 0) quiet++;
        else quiet = 0;
    end
endmodule

>>> files.f
hw/rtl/lmf_pkg.sv
hw/rtl/lmf_in_if.sv
hw/rtl/lmf_out_if.sv
hw/rtl/luminance_median_filter_3x3.sv
hw/rtl/lmf_checker.sv
tb/tb_luminance_median_filter_3x3.sv
